### rtl/core/esbc_pkg.sv
package esbc_pkg;

  localparam int KIND_W   = 3;
  localparam int BEEP_W   = 2;
  localparam int EVENT_W  = 3;
  localparam int TONE_W   = 2;
  localparam int UNIT_W   = 10;
  localparam int HOLD_W   = 16;
  localparam int LOCK_W   = 16;
  localparam int COUNT_W  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_ENC   = 3'd1,
    KIND_SW    = 3'd2,
    KIND_BEEP  = 3'd3,
    KIND_MENU  = 3'd4
  } kind_t;

  typedef enum logic [BEEP_W-1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_SHORT = 2'd1,
    BEEP_ENTER = 2'd2,
    BEEP_BACK  = 2'd3
  } beep_t;

  typedef enum logic [1:0] {
    MODE_SHORT = 2'd0,
    MODE_ENTER = 2'd1,
    MODE_BACK  = 2'd2
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE  = 3'd0,
    EV_INC   = 3'd1,
    EV_DEC   = 3'd2,
    EV_CLICK = 3'd3,
    EV_BACK  = 3'd4
  } event_t;

  typedef enum logic [TONE_W-1:0] {
    TONE_0 = 2'd0,
    TONE_1 = 2'd1,
    TONE_2 = 2'd2
  } tone_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEEP_UNIT = 2'd0,
    REG_HOLD      = 2'd1,
    REG_LOCKOUT   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    kind_t             kind;
    logic              enc_a;
    logic              enc_b;
    logic              switch_level;
    logic [BEEP_W-1:0] beep_type;
  } item_t;

  typedef struct packed {
    event_t            event_code;
    logic              buzzer_on;
    logic [TONE_W-1:0] tone_select;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] unit_x1;
    logic [COUNT_W-1:0] unit_x3;
    logic [COUNT_W-1:0] unit_x6;
    logic [COUNT_W-1:0] unit_x8;
    logic [HOLD_W-1:0]  hold_ticks;
    logic [LOCK_W-1:0]  lockout_ticks;
  } cfg_t;

endpackage

### rtl/core/esbc_in_if.sv
interface esbc_in_if;
  import esbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              enc_a;
  logic              enc_b;
  logic              switch_level;
  logic [BEEP_W-1:0] beep_type;

  modport source (output valid, kind, enc_a, enc_b, switch_level, beep_type, input ready);
  modport sink   (input valid, kind, enc_a, enc_b, switch_level, beep_type, output ready);
endinterface

### rtl/core/esbc_out_if.sv
interface esbc_out_if;
  import esbc_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_code;
  logic               buzzer_on;
  logic [TONE_W-1:0]  tone_select;

  modport source (output valid, event_code, buzzer_on, tone_select, input ready);
  modport sink   (input valid, event_code, buzzer_on, tone_select, output ready);
endinterface

### rtl/core/esbc_cfg.sv
module esbc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [esbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output esbc_pkg::cfg_t                   cfg
);
  import esbc_pkg::*;

  logic [COUNT_W-1:0] unit_w;

  assign unit_w = COUNT_W'(cfg_data[UNIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_x1       <= COUNT_W'(1);
      cfg.unit_x3       <= COUNT_W'(3);
      cfg.unit_x6       <= COUNT_W'(6);
      cfg.unit_x8       <= COUNT_W'(8);
      cfg.hold_ticks    <= HOLD_W'(1);
      cfg.lockout_ticks <= LOCK_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BEEP_UNIT: begin
          cfg.unit_x1 <= unit_w;
          cfg.unit_x3 <= unit_w + (unit_w << 1);
          cfg.unit_x6 <= (unit_w << 2) + (unit_w << 1);
          cfg.unit_x8 <= unit_w << 3;
        end
        REG_HOLD:    cfg.hold_ticks    <= cfg_data[HOLD_W-1:0];
        REG_LOCKOUT: cfg.lockout_ticks <= cfg_data[LOCK_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/esbc_engine.sv
module esbc_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  esbc_pkg::item_t   item,
  input  esbc_pkg::cfg_t    cfg,
  output esbc_pkg::result_t res
);
  import esbc_pkg::*;

  logic [COUNT_W-1:0] beep_count, beep_count_next;
  mode_t              beep_mode, beep_mode_next;
  tone_t              tone_reg, tone_reg_next;
  logic [HOLD_W-1:0]  hold_count, hold_count_next;
  logic [LOCK_W-1:0]  lockout_count, lockout_count_next;
  event_t             ev;
  logic               buz;

  always_comb begin
    beep_count_next    = beep_count;
    beep_mode_next     = beep_mode;
    tone_reg_next      = tone_reg;
    hold_count_next    = hold_count;
    lockout_count_next = lockout_count;
    ev                 = EV_NONE;
    buz                = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (beep_count != '0) begin
          buz = 1'b1;
          unique case (beep_mode)
            MODE_ENTER: begin
              if (beep_count == cfg.unit_x8) tone_reg_next = TONE_0;
              if (beep_count == cfg.unit_x6) tone_reg_next = TONE_1;
            end
            MODE_BACK: begin
              if (beep_count == cfg.unit_x6) tone_reg_next = TONE_0;
              if (beep_count == cfg.unit_x3) tone_reg_next = TONE_2;
            end
            default: tone_reg_next = TONE_0;
          endcase
          beep_count_next = beep_count - COUNT_W'(1);
        end
        if (hold_count != '0) begin
          if (hold_count == HOLD_W'(1)) begin
            beep_mode_next  = MODE_BACK;
            beep_count_next = cfg.unit_x6;
            ev              = EV_BACK;
          end
          hold_count_next = hold_count - HOLD_W'(1);
        end
        if (lockout_count != '0) lockout_count_next = lockout_count - LOCK_W'(1);
      end
      KIND_ENC: begin
        if (lockout_count == '0) begin
          beep_mode_next  = MODE_SHORT;
          beep_count_next = cfg.unit_x1;
          ev              = (item.enc_a == item.enc_b) ? EV_DEC : EV_INC;
        end
      end
      KIND_SW: begin
        if (lockout_count == '0) begin
          if (item.switch_level) begin
            hold_count_next = cfg.hold_ticks;
          end else begin
            beep_mode_next     = MODE_ENTER;
            beep_count_next    = cfg.unit_x8;
            lockout_count_next = cfg.lockout_ticks >> 1;
            if (hold_count != '0) begin
              hold_count_next = '0;
              ev              = EV_CLICK;
            end
          end
        end
      end
      KIND_BEEP: begin
        unique case (beep_t'(item.beep_type))
          BEEP_SHORT: begin
            beep_mode_next  = MODE_SHORT;
            beep_count_next = cfg.unit_x1;
          end
          BEEP_ENTER: begin
            beep_mode_next  = MODE_ENTER;
            beep_count_next = cfg.unit_x8;
          end
          BEEP_BACK: begin
            beep_mode_next  = MODE_BACK;
            beep_count_next = cfg.unit_x6;
          end
          default: ;
        endcase
      end
      KIND_MENU: lockout_count_next = cfg.lockout_ticks;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beep_count    <= '0;
      beep_mode     <= MODE_SHORT;
      tone_reg      <= TONE_0;
      hold_count    <= '0;
      lockout_count <= '0;
    end else if (fire) begin
      beep_count    <= beep_count_next;
      beep_mode     <= beep_mode_next;
      tone_reg      <= tone_reg_next;
      hold_count    <= hold_count_next;
      lockout_count <= lockout_count_next;
    end
  end

  assign res.event_code  = ev;
  assign res.buzzer_on   = buz;
  assign res.tone_select = tone_reg_next;
endmodule

### rtl/core/encoder_switch_beeper_controller_top.sv
// A word accepted into the input register has its result registered in the result register when the engine fires.
// Throughput: one word per cycle while result words are taken, set by the single input register and result register.
// A result word that waits holds the engine; the input register takes one more word if it is empty, then
// ready drops until the result word is taken.
// Reset (rst, synchronous, active high): clears both stage valids and all counters and
// sets the beep unit, hold and lockout configuration values to one.
module encoder_switch_beeper_controller_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [esbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esbc_pkg::CFG_DATA_W-1:0] cfg_data,
  esbc_in_if.sink                          in_ch,
  esbc_out_if.source                       out_ch
);
  import esbc_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld;
  result_t res;
  result_t out_q;
  logic    out_vld;
  logic    move;

  assign move        = in_vld && (!out_vld || out_ch.ready);
  assign in_ch.ready = !in_vld || move;

  esbc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  esbc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (move),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      if (in_ch.ready) in_vld <= in_ch.valid;
      if (move) begin
        out_vld <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.kind         <= kind_t'(in_ch.kind);
      in_q.enc_a        <= in_ch.enc_a;
      in_q.enc_b        <= in_ch.enc_b;
      in_q.switch_level <= in_ch.switch_level;
      in_q.beep_type    <= in_ch.beep_type;
    end
    if (move) out_q <= res;
  end

  assign out_ch.valid       = out_vld;
  assign out_ch.event_code  = out_q.event_code;
  assign out_ch.buzzer_on   = out_q.buzzer_on;
  assign out_ch.tone_select = out_q.tone_select;
endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import esbc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned IDLE_PCT = 7;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } panel_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  esbc_in_if  in_ch ();
  esbc_out_if out_ch ();

  encoder_switch_beeper_controller_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #1 clk = ~clk;

  // panel model state
  logic [UNIT_W-1:0]  unit_r     = 10'd1;
  logic [HOLD_W-1:0]  hold_r     = 16'd1;
  logic [LOCK_W-1:0]  lock_r     = 16'd1;
  logic [COUNT_W-1:0] beep_left  = '0;
  mode_t              beep_mode  = MODE_SHORT;
  tone_t              tone_r     = TONE_0;
  logic [HOLD_W-1:0]  hold_left  = '0;
  logic [LOCK_W-1:0]  lock_left  = '0;

  result_t     panel_responses [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  panel_row_t panel_rows [27] = '{
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b1, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_ENC,  1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b1, '{EV_DEC,   1'b0, TONE_0}},
    '{'{KIND_ENC,  1'b1, 1'b0, 1'b0, BEEP_NONE},  1'b1, '{EV_INC,   1'b0, TONE_0}},
    '{'{KIND_ENC,  1'b0, 1'b1, 1'b0, BEEP_NONE},  1'b1, '{EV_INC,   1'b0, TONE_0}},
    '{'{KIND_ENC,  1'b1, 1'b1, 1'b0, BEEP_NONE},  1'b1, '{EV_DEC,   1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b1, '{EV_NONE,  1'b1, TONE_0}},
    '{'{KIND_SW,   1'b0, 1'b0, 1'b1, BEEP_NONE},  1'b1, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_SW,   1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b1, '{EV_CLICK, 1'b0, TONE_0}},
    '{'{KIND_SW,   1'b0, 1'b0, 1'b1, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_MENU, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_ENC,  1'b1, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_SW,   1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_BEEP, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_BEEP, 1'b0, 1'b0, 1'b0, BEEP_ENTER}, 1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_TICK, 1'b0, 1'b0, 1'b0, BEEP_NONE},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_BEEP, 1'b0, 1'b0, 1'b0, BEEP_BACK},  1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{KIND_BEEP, 1'b0, 1'b0, 1'b0, BEEP_SHORT}, 1'b0, '{EV_NONE,  1'b0, TONE_0}},
    '{'{kind_t'(KIND_SPARE_LO), 1'b0, 1'b0, 1'b0, BEEP_NONE}, 1'b0,
      '{EV_NONE, 1'b0, TONE_0}},
    '{'{kind_t'(KIND_SPARE_HI), 1'b1, 1'b1, 1'b1, BEEP_BACK}, 1'b0,
      '{EV_NONE, 1'b0, TONE_0}}
  };

  function automatic void start_tone(input mode_t m, input int unsigned mult);
    beep_mode = m;
    beep_left = COUNT_W'(int'(unit_r) * mult);
  endfunction

  function automatic result_t panel_step(input item_t w);
    result_t r;
    r.event_code = EV_NONE;
    r.buzzer_on  = 1'b0;
    case (w.kind)
      KIND_TICK: begin
        if (beep_left != '0) begin
          r.buzzer_on = 1'b1;
          case (beep_mode)
            MODE_ENTER: begin
              if (int'(beep_left) == int'(unit_r) * 8) tone_r = TONE_0;
              if (int'(beep_left) == int'(unit_r) * 6) tone_r = TONE_1;
            end
            MODE_BACK: begin
              if (int'(beep_left) == int'(unit_r) * 6) tone_r = TONE_0;
              if (int'(beep_left) == int'(unit_r) * 3) tone_r = TONE_2;
            end
            default: tone_r = TONE_0;
          endcase
          beep_left = beep_left - 1'b1;
        end
        if (hold_left != '0) begin
          if (hold_left == 16'd1) begin
            start_tone(MODE_BACK, 6);
            r.event_code = EV_BACK;
          end
          hold_left = hold_left - 1'b1;
        end
        if (lock_left != '0) lock_left = lock_left - 1'b1;
      end
      KIND_ENC: begin
        if (lock_left == '0) begin
          start_tone(MODE_SHORT, 1);
          r.event_code = (w.enc_a == w.enc_b) ? EV_DEC : EV_INC;
        end
      end
      KIND_SW: begin
        if (lock_left == '0) begin
          if (w.switch_level) begin
            hold_left = hold_r;
          end else begin
            start_tone(MODE_ENTER, 8);
            lock_left = lock_r >> 1;
            if (hold_left != '0) begin
              hold_left = '0;
              r.event_code = EV_CLICK;
            end
          end
        end
      end
      KIND_BEEP: begin
        case (w.beep_type)
          BEEP_SHORT: start_tone(MODE_SHORT, 1);
          BEEP_ENTER: start_tone(MODE_ENTER, 8);
          BEEP_BACK:  start_tone(MODE_BACK, 6);
          default: ;
        endcase
      end
      KIND_MENU: lock_left = lock_r;
      default: ;
    endcase
    r.tone_select = tone_r;
    return r;
  endfunction

  function automatic item_t random_word();
    item_t w;
    int unsigned pick;
    w.enc_a        = 1'($urandom);
    w.enc_b        = 1'($urandom);
    w.switch_level = 1'($urandom);
    w.beep_type    = 2'($urandom);
    pick = $urandom_range(99);
    if (pick < 50)      w.kind = KIND_TICK;
    else if (pick < 67) w.kind = KIND_ENC;
    else if (pick < 84) w.kind = KIND_SW;
    else if (pick < 94) w.kind = KIND_BEEP;
    else if (pick < 96) w.kind = KIND_MENU;
    else                w.kind = kind_t'(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)));
    return w;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    result_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= w.kind;
    in_ch.enc_a        <= w.enc_a;
    in_ch.enc_b        <= w.enc_b;
    in_ch.switch_level <= w.switch_level;
    in_ch.beep_type    <= w.beep_type;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = panel_step(w);
    panel_responses.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      REG_BEEP_UNIT: unit_r = UNIT_W'(value);
      REG_HOLD:      hold_r = HOLD_W'(value);
      REG_LOCKOUT:   lock_r = LOCK_W'(value);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input int unsigned unit, input int unsigned hold,
                          input int unsigned lock);
    write_reg(REG_BEEP_UNIT, unit);
    write_reg(REG_HOLD, hold);
    write_reg(REG_LOCKOUT, lock);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (panel_responses.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned n_words, input int unsigned max_run);
    int unsigned sent;
    int unsigned run_len;
    item_t w;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 8) begin
        run_len = $urandom_range(4, max_run);
        repeat (run_len) begin
          w = random_word();
          w.kind = KIND_TICK;
          send_word(w, 1'b0, '0);
        end
        sent += run_len;
      end else begin
        send_word(random_word(), 1'b0, '0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.event_code  = event_t'(out_ch.event_code);
      got.buzzer_on   = out_ch.buzzer_on;
      got.tone_select = out_ch.tone_select;
      if (panel_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word: event %0d buzzer %0b tone %0d", $realtime,
                   got.event_code, got.buzzer_on, got.tone_select);
      end else begin
        want = panel_responses.pop_front();
        if (got.event_code !== want.event_code || got.buzzer_on !== want.buzzer_on ||
            got.tone_select !== want.tone_select) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected %0d/%0b/%0d got %0d/%0b/%0d",
                     $realtime, want.event_code, want.buzzer_on, want.tone_select,
                     got.event_code, got.buzzer_on, got.tone_select);
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned i;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_BEEP_UNIT;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.kind         = KIND_TICK;
    in_ch.enc_a        = 1'b0;
    in_ch.enc_b        = 1'b0;
    in_ch.switch_level = 1'b1;
    in_ch.beep_type    = BEEP_NONE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(panel_rows); i++)
      send_word(panel_rows[i].word, panel_rows[i].typed, panel_rows[i].want);
    in_ch.valid <= 1'b0;
    drain();

    for (i = 0; i < 5; i++) begin
      set_regs($urandom_range(1, 6), $urandom_range(1, 30), $urandom_range(1, 20));
      steady = (i == 2);
      run_phase(300, 8 * int'(unit_r) + 8);
      drain();
    end
    steady = 1'b0;

    // zero lengths: silent buzzer, no hold, no lockout
    set_regs(0, 0, 0);
    run_phase(150, 20);
    drain();

    set_regs(1, 1, 1);
    write_reg(REG_SPARE, 16'hffff);
    cfg_we <= 1'b0;
    run_phase(150, 12);
    drain();

    set_regs(1023, 2, 3);
    run_phase(150, 150);
    drain();

    set_regs(1023, 65535, 65535);
    run_phase(100, 40);
    drain();

    if (mismatches == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
